>>> rtl/mcs_pkg.sv
// Package for the monotone cubic spline interpolator: payload structs, status codes, constants.
// Used by mcs_front, mcs_back, the top level and mcs_checker in rtl/.
`default_nettype none
package mcs_pkg;
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int COEF_W           = 36;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOTREADY = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;
    localparam t_status ST_FEW      = 2'd3;

    localparam logic FN_LOAD = 1'b0;
    localparam logic FN_EVAL = 1'b1;

    localparam logic CFG_X_ORIGIN     = 1'b0;
    localparam logic CFG_INVERSE_STEP = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] sample_value;
        logic               last_sample;
        logic signed [31:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        t_status            status;
    } t_out_item;
endpackage
`default_nettype wire

>>> rtl/mcs_queue.sv
// Two-entry FIFO between front and back end of the spline interpolator.
// Depends on nothing but its width parameter.
`default_nettype none
module mcs_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

>>> rtl/mcs_front.sv
// Front end: accepts items, runs the load window and slope limiter, writes segment
// coefficients, and forwards classified jobs. Depends on mcs_pkg.
`default_nettype none
module mcs_front #(
    parameter int MAX_SEGMENTS = mcs_pkg::MAX_SEGMENTS_DEF,
    parameter int SEG_W        = $clog2(MAX_SEGMENTS),
    parameter int CNT_W        = $clog2(MAX_SEGMENTS + 3)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mcs_pkg::t_in_item i_item,
    // job to back end: {eval, status, x}
    output logic                   o_job_valid,
    input  wire logic              i_job_ready,
    output logic [34:0]            o_job,
    output logic [CNT_W-1:0]       o_segs,
    // high when the queue is empty and the back end is idle
    input  wire logic              i_down_idle,
    // coefficient write port
    output logic                   o_cw_en,
    output logic [SEG_W-1:0]       o_cw_addr,
    output logic [3*mcs_pkg::COEF_W+31:0] o_cw_data
);
    import mcs_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SEG_A, S_SEG_B} t_state;

    t_state               r_state, n_state;
    logic signed [31:0]   r_w [3];
    logic signed [31:0]   n_w [3];
    logic [CNT_W-1:0]     r_loaded, n_loaded, r_segs, n_segs;
    logic signed [31:0]   r_s, n_s;
    logic                 r_last, n_last;
    logic [CNT_W-1:0]     r_j, n_j;
    logic                 r_cw_en, n_cw_en;
    logic [SEG_W-1:0]     r_cw_addr, n_cw_addr;
    logic [3*COEF_W+31:0] r_cw_data, n_cw_data;
    logic                 r_job_valid, n_job_valid;
    logic [34:0]          r_job, n_job;

    localparam logic [CNT_W-1:0] OVF_AT = CNT_W'(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] OVF_MK = CNT_W'(MAX_SEGMENTS + 2);

    function automatic logic signed [35:0] lim(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
        logic signed [35:0] m, lo, hi, a0, b0, a1, b1;
        m  = (a + b) >>> 1;
        a0 = (a < 0) ? a : 36'sd0;
        b0 = (b < 0) ? b : 36'sd0;
        a1 = (a > 0) ? a : 36'sd0;
        b1 = (b > 0) ? b : 36'sd0;
        lo = 3 * ((a0 > b0) ? a0 : b0);
        hi = 3 * ((a1 < b1) ? a1 : b1);
        if (m < lo) m = lo;
        if (m > hi) m = hi;
        return m;
    endfunction

    function automatic logic [3*COEF_W+31:0] seg(input logic signed [31:0] base,
        input logic signed [35:0] d0, input logic signed [35:0] d1,
        input logic signed [35:0] d2);
        logic signed [35:0] m0, m1, c3, c2;
        m0 = lim(d0, d1);
        m1 = lim(d1, d2);
        c3 = -2 * d1 + m0 + m1;
        c2 = 3 * d1 - 2 * m0 - m1;
        return {c3, c2, m0, base};
    endfunction

    logic signed [35:0] e0, e1, e2, es;
    assign e0 = 36'(r_w[0]);
    assign e1 = 36'(r_w[1]);
    assign e2 = 36'(r_w[2]);
    assign es = 36'(r_s);

    // first sample of a load waits until no job is in flight downstream (queue empty, back end idle)
    logic accept;
    assign o_ready = (r_state == S_IDLE) && i_job_ready && !r_job_valid
                     && (i_item.func == FN_EVAL || r_loaded != '0 || i_down_idle);
    assign accept  = i_valid && o_ready;

    assign o_cw_en     = r_cw_en;
    assign o_cw_addr   = r_cw_addr;
    assign o_cw_data   = r_cw_data;
    assign o_segs      = r_segs;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_loaded    = r_loaded;
        n_segs      = r_segs;
        n_s         = r_s;
        n_last      = r_last;
        n_j         = r_j;
        n_cw_en     = 1'b0;
        n_cw_addr   = r_cw_addr;
        n_cw_data   = r_cw_data;
        n_job_valid = 1'b0;
        n_job       = r_job;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.func == FN_EVAL) begin
                        n_job_valid = 1'b1;
                        n_job = {1'b1, (r_segs == '0) ? ST_NOTREADY : ST_OK,
                                 i_item.query_x};
                    end else begin
                        if (r_loaded == '0) n_segs = '0;
                        if (r_loaded >= OVF_AT) begin
                            n_loaded = i_item.last_sample ? '0 : OVF_MK;
                            n_job_valid = 1'b1;
                            n_job = {1'b0, ST_OVERFLOW, 32'd0};
                        end else begin
                            n_s = i_item.sample_value;
                            n_last = i_item.last_sample;
                            n_j = r_loaded;
                            n_state = S_SEG_A;
                        end
                    end
                end
            end
            S_SEG_A: begin
                if (r_j == CNT_W'(2)) begin
                    n_cw_en = 1'b1;
                    n_cw_addr = '0;
                    n_cw_data = seg(r_w[1], e2 - e1, e2 - e1, es - e2);
                end else if (r_j >= CNT_W'(3)
                             && (r_j - CNT_W'(2)) < CNT_W'(MAX_SEGMENTS)) begin
                    n_cw_en = 1'b1;
                    n_cw_addr = SEG_W'(r_j - CNT_W'(2));
                    n_cw_data = seg(r_w[1], e1 - e0, e2 - e1, es - e2);
                end
                n_state = S_SEG_B;
            end
            S_SEG_B: begin
                if (r_last && r_j >= CNT_W'(2)
                    && (r_j - CNT_W'(1)) < CNT_W'(MAX_SEGMENTS)) begin
                    n_cw_en = 1'b1;
                    n_cw_addr = SEG_W'(r_j - CNT_W'(1));
                    n_cw_data = seg(r_w[2], e2 - e1, es - e2, es - e2);
                end
                n_w[0] = r_w[1];
                n_w[1] = r_w[2];
                n_w[2] = r_s;
                if (r_last) begin
                    n_loaded = '0;
                    if (r_j >= CNT_W'(2)) n_segs = r_j;
                end else begin
                    n_loaded = r_j + CNT_W'(1);
                end
                n_job_valid = 1'b1;
                n_job = {1'b0, (r_last && r_j < CNT_W'(2)) ? ST_FEW : ST_OK, 32'd0};
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w[0]      <= '0;
            r_w[1]      <= '0;
            r_w[2]      <= '0;
            r_loaded    <= '0;
            r_segs      <= '0;
            r_s         <= '0;
            r_last      <= 1'b0;
            r_j         <= '0;
            r_cw_en     <= 1'b0;
            r_cw_addr   <= '0;
            r_cw_data   <= '0;
            r_job_valid <= 1'b0;
            r_job       <= '0;
        end else begin
            r_state     <= n_state;
            r_w[0]      <= n_w[0];
            r_w[1]      <= n_w[1];
            r_w[2]      <= n_w[2];
            r_loaded    <= n_loaded;
            r_segs      <= n_segs;
            r_s         <= n_s;
            r_last      <= n_last;
            r_j         <= n_j;
            r_cw_en     <= n_cw_en;
            r_cw_addr   <= n_cw_addr;
            r_cw_data   <= n_cw_data;
            r_job_valid <= n_job_valid;
            r_job       <= n_job;
        end
    end
endmodule
`default_nettype wire

>>> rtl/mcs_back.sv
// Back end: maps x to segment and t, reads coefficients, Horner evaluation, saturation.
// Holds the coefficient memory. Depends on mcs_pkg.
`default_nettype none
module mcs_back #(
    parameter int MAX_SEGMENTS = mcs_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = mcs_pkg::FRAC_BITS_DEF,
    parameter int SEG_W        = $clog2(MAX_SEGMENTS),
    parameter int CNT_W        = $clog2(MAX_SEGMENTS + 3)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    output logic                    o_job_ready,
    input  wire logic [34:0]        i_job,
    input  wire logic [CNT_W-1:0]   i_segs,
    input  wire logic signed [31:0] i_x_origin,
    input  wire logic [31:0]        i_inverse_step,
    input  wire logic               i_cw_en,
    input  wire logic [SEG_W-1:0]   i_cw_addr,
    input  wire logic [3*mcs_pkg::COEF_W+31:0] i_cw_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output mcs_pkg::t_out_item      o_item
);
    import mcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MAP, S_RD, S_H1, S_H2, S_H3, S_H4, S_OUT
    } t_state;

    localparam int TW = FRAC_BITS + 1;
    localparam int AW = COEF_W + 12;
    localparam int KW = 64 - 2*FRAC_BITS + 1;
    localparam logic signed [AW-1:0] SAT_HI = AW'(longint'(32'sh7fffffff));
    localparam logic signed [AW-1:0] SAT_LO = AW'(longint'(32'sh80000000));

    logic [3*COEF_W+31:0] r_mem [MAX_SEGMENTS];
    logic [3*COEF_W+31:0] r_rd;

    t_state               r_state, n_state;
    logic signed [32:0]   r_diff, n_diff;
    logic [64:0]          r_prod, n_prod;
    logic [SEG_W-1:0]     r_k, n_k;
    logic [TW-1:0]        r_t, n_t;
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_valid, n_valid;
    t_out_item            r_item, n_item;

    logic [KW-1:0]          kk;
    logic [CNT_W-1:0]       last_seg;
    logic [COEF_W-1:0]      c3, c2, c1;
    logic [31:0]            c0;
    logic signed [AW+TW:0]  mul;
    logic signed [AW-1:0]   sh, fin;

    assign kk       = r_prod[64:2*FRAC_BITS];
    assign last_seg = i_segs - CNT_W'(1);
    assign c3  = r_rd[3*COEF_W+31 -: COEF_W];
    assign c2  = r_rd[2*COEF_W+31 -: COEF_W];
    assign c1  = r_rd[COEF_W+31 -: COEF_W];
    assign c0  = r_rd[31:0];
    assign mul = r_acc * $signed({1'b0, r_t});
    assign sh  = AW'(mul >>> FRAC_BITS);
    assign fin = sh + AW'(signed'(c0));

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (i_cw_en) r_mem[i_cw_addr] <= i_cw_data;
        r_rd <= r_mem[r_k];
    end

    always_comb begin
        n_state = r_state;
        n_diff  = r_diff;
        n_prod  = r_prod;
        n_k     = r_k;
        n_t     = r_t;
        n_acc   = r_acc;
        n_valid = r_valid;
        n_item  = r_item;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_diff = 33'(signed'(i_job[31:0])) - 33'(i_x_origin);
                    if (i_job[34] && i_job[33:32] == ST_OK) begin
                        n_state = S_MUL;
                    end else begin
                        n_item.result_value = '0;
                        n_item.status = i_job[33:32];
                        n_valid = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL: begin
                n_prod = (r_diff > 33'sd0) ? {32'd0, r_diff} * {33'd0, i_inverse_step} : '0;
                n_state = S_MAP;
            end
            S_MAP: begin
                n_t = TW'(r_prod[2*FRAC_BITS-1:FRAC_BITS]);
                n_k = SEG_W'(kk);
                if (kk >= KW'(last_seg)) begin
                    if (kk > KW'(last_seg)) n_t = TW'(1) << FRAC_BITS;
                    n_k = SEG_W'(last_seg);
                end
                n_state = S_RD;
            end
            S_RD: begin
                // coefficient read of r_k lands in r_rd
                n_state = S_H1;
            end
            S_H1: begin
                n_acc = AW'(signed'(c3));
                n_state = S_H2;
            end
            S_H2: begin
                n_acc = sh + AW'(signed'(c2));
                n_state = S_H3;
            end
            S_H3: begin
                n_acc = sh + AW'(signed'(c1));
                n_state = S_H4;
            end
            S_H4: begin
                if (fin > SAT_HI)
                    n_item.result_value = 32'sh7fffffff;
                else if (fin < SAT_LO)
                    n_item.result_value = 32'sh80000000;
                else
                    n_item.result_value = 32'(fin);
                n_item.status = ST_OK;
                n_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_diff  <= '0;
            r_prod  <= '0;
            r_k     <= '0;
            r_t     <= '0;
            r_acc   <= '0;
            r_valid <= 1'b0;
            r_item  <= '0;
        end else begin
            r_state <= n_state;
            r_diff  <= n_diff;
            r_prod  <= n_prod;
            r_k     <= n_k;
            r_t     <= n_t;
            r_acc   <= n_acc;
            r_valid <= n_valid;
            r_item  <= n_item;
        end
    end
endmodule
`default_nettype wire

>>> rtl/monotone_cubic_spline_interpolator_top.sv
// Top level of the monotone cubic spline interpolator: config registers, front, queue, back.
// Depends on mcs_pkg, mcs_front, mcs_queue, mcs_back.
//
// channel | dir | handshake
// in      | in  | i_in_valid / o_in_ready, payload i_in_item
// out     | out | o_out_valid / i_out_ready, payload o_out_item
// cfg     | in  | i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// Load beat: the front end steps through S_SEG_A and S_SEG_B (up to two coefficient writes),
// then hands off the job; an overflowing load beat hands off its status job directly.
// Evaluate beat: the result passes the queue, then the back end's multiply, map, memory
// read and four Horner/saturate steps; a new job waits until the last result is taken.
// First sample of a load stalls until the queue is empty and the back end is idle.
// Reset is synchronous; the coefficient memory is not cleared.
`default_nettype none
module monotone_cubic_spline_interpolator_top #(
    parameter int MAX_SEGMENTS = mcs_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = mcs_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mcs_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output mcs_pkg::t_out_item     o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);
    import mcs_pkg::*;

    localparam int SEG_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 3);

    logic signed [31:0] r_x_origin;
    logic [31:0]        r_inverse_step;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_inverse_step <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X_ORIGIN:     r_x_origin <= i_cfg_data;
                CFG_INVERSE_STEP: r_inverse_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                 f_valid, f_ready, q_valid, q_ready;
    logic [34:0]          f_job, q_job;
    logic [CNT_W-1:0]     segs;
    logic                 down_idle;
    logic                 cw_en;
    logic [SEG_W-1:0]     cw_addr;
    logic [3*COEF_W+31:0] cw_data;

    assign down_idle = q_ready && !q_valid;

    mcs_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .SEG_W(SEG_W), .CNT_W(CNT_W)) u_front (
        .i_clk, .i_rst_n, .i_valid(i_in_valid), .o_ready(o_in_ready), .i_item(i_in_item),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job), .o_segs(segs),
        .i_down_idle(down_idle),
        .o_cw_en(cw_en), .o_cw_addr(cw_addr), .o_cw_data(cw_data)
    );

    mcs_queue #(.W(35)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_job)
    );

    mcs_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS),
               .SEG_W(SEG_W), .CNT_W(CNT_W)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .i_segs(segs), .i_x_origin(r_x_origin), .i_inverse_step(r_inverse_step),
        .i_cw_en(cw_en), .i_cw_addr(cw_addr), .i_cw_data(cw_data),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_item(o_out_item)
    );
endmodule
`default_nettype wire

>>> rtl/mcs_checker.sv
// Port-level checker for the spline interpolator, bound to the top level.
// Depends on mcs_pkg.
`default_nettype none
module mcs_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire mcs_pkg::t_out_item o_out_item
);
    import mcs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("out beat dropped");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.result_value == 0)
        else $error("nonzero value on error status");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("valid after reset");
endmodule

bind monotone_cubic_spline_interpolator_top mcs_checker u_chk (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_ready, .o_out_item
);
`default_nettype wire

>>> tb/tb_monotone_cubic_spline_interpolator_top.sv
// Testbench for monotone_cubic_spline_interpolator_top: loads spline tables, evaluates
// queries and checks every output beat against an in-bench spline predictor.
// Depends on mcs_pkg and the top-level RTL.
`timescale 1ns / 100ps
module tb_monotone_cubic_spline_interpolator_top;
    import mcs_pkg::*;

    localparam int NSEG = 256;
    localparam int FB   = 16;
    localparam int LIMIT_CYCLES = 900000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    monotone_cubic_spline_interpolator_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    longint      x_org;
    longint      inv_step;
    longint      win[3];
    int          n_loaded;
    int          seg_valid;
    longint      c3[NSEG];
    longint      c2[NSEG];
    longint      c1[NSEG];
    longint      c0[NSEG];

    t_in_item    pending_beats[$];
    t_out_item   expected_results[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_in = 1'b1;
    int          in_gap = 0;
    int          out_gap = 0;

    function automatic void add_beat(t_in_item it);
        pending_beats = {pending_beats, it};
    endfunction

    function automatic longint fshift(longint v);
        return v >>> FB;
    endfunction

    function automatic longint slope_lim(longint da, longint db);
        longint m, lo, hi;
        m  = (da + db) >>> 1;
        lo = 3 * ((da < 0 ? da : 0) > (db < 0 ? db : 0) ? (da < 0 ? da : 0) : (db < 0 ? db : 0));
        hi = 3 * ((da > 0 ? da : 0) < (db > 0 ? db : 0) ? (da > 0 ? da : 0) : (db > 0 ? db : 0));
        if (m < lo) m = lo;
        if (m > hi) m = hi;
        return m;
    endfunction

    function automatic void store_segment(int k, longint base, longint d0, longint d1,
                                          longint d2);
        longint m0, m1;
        m0 = slope_lim(d0, d1);
        m1 = slope_lim(d1, d2);
        if (k >= NSEG) return;
        c3[k] = -2 * d1 + m0 + m1;
        c2[k] = 3 * d1 - 2 * m0 - m1;
        c1[k] = m0;
        c0[k] = base;
    endfunction

    function automatic longint spline_value(longint x);
        longint diff, k, t, acc;
        logic [63:0] prod;
        diff = x - x_org;
        k = 0;
        t = 0;
        if (diff > 0) begin
            prod = 64'(diff) * 64'(inv_step);
            k = longint'(prod >> (2 * FB));
            t = longint'((prod >> FB) - (64'(k) << FB));
            if (k >= seg_valid - 1) begin
                if (k > seg_valid - 1) t = longint'(1) << FB;
                k = seg_valid - 1;
            end
        end
        if (k >= NSEG) k = NSEG - 1;
        acc = c3[k];
        acc = fshift(acc * t) + c2[k];
        acc = fshift(acc * t) + c1[k];
        acc = fshift(acc * t) + c0[k];
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc;
    endfunction

    function automatic t_out_item predict_beat(t_in_item it);
        t_out_item r;
        longint s, w0, w1, w2;
        int j;
        r = '0;
        r.status = ST_OK;
        if (it.func == FN_EVAL) begin
            if (seg_valid == 0) r.status = ST_NOTREADY;
            else r.result_value = 32'(spline_value(longint'(it.query_x)));
        end else begin
            s = longint'(it.sample_value);
            j = n_loaded;
            if (j == 0) seg_valid = 0;
            if (j >= NSEG + 1) begin
                n_loaded = NSEG + 2;
                r.status = ST_OVERFLOW;
                if (it.last_sample) n_loaded = 0;
            end else begin
                w0 = win[0]; w1 = win[1]; w2 = win[2];
                if (j == 2) store_segment(0, w1, w2 - w1, w2 - w1, s - w2);
                else if (j >= 3) store_segment(j - 2, w1, w1 - w0, w2 - w1, s - w2);
                if (it.last_sample && j >= 2) store_segment(j - 1, w2, w2 - w1, s - w2, s - w2);
                win[0] = w1; win[1] = w2; win[2] = s;
                n_loaded = j + 1;
                if (it.last_sample) begin
                    if (j < 2) r.status = ST_FEW;
                    else seg_valid = j;
                    n_loaded = 0;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_results = {expected_results, predict_beat(in_item)};
            end
            if (!(in_valid && !in_ready)) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (!hold_in && pending_beats.size() > 0) begin
                    in_item <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 19) == 0) in_gap <= $urandom_range(1, 15);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", out_item.result_value, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.status !== want.status)
                        report_mismatch("status", out_item.status, want.status);
                    if (out_item.result_value !== want.result_value)
                        report_mismatch("value", out_item.result_value, want.result_value);
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 19) == 0) out_gap <= $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_in_item load_beat(logic signed [31:0] v, logic last);
        t_in_item it;
        it = '0;
        it.func = FN_LOAD;
        it.sample_value = v;
        it.last_sample = last;
        it.query_x = $urandom;
        return it;
    endfunction

    function automatic t_in_item eval_beat(logic signed [31:0] x);
        t_in_item it;
        it = '0;
        it.func = FN_EVAL;
        it.query_x = x;
        it.sample_value = $urandom;
        it.last_sample = $urandom_range(0, 1);
        return it;
    endfunction

    task automatic drain();
        hold_in = 1'b0;
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        hold_in = 1'b1;
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_X_ORIGIN) x_org = longint'($signed(data));
        else inv_step = longint'(data);
    endtask

    task automatic queue_table(int n, int kind);
        logic signed [31:0] v;
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: v = $urandom;
                1: v = $signed($urandom_range(0, 131072)) - 65536;
                default: v = i * 65536 + $urandom_range(0, 40000);
            endcase
            add_beat(load_beat(v, i == n - 1));
        end
    endtask

    task automatic queue_queries(int n);
        logic signed [31:0] x;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: x = $urandom;
                1: x = 32'(x_org) + $urandom_range(0, 1 << 22);
                2: x = 32'(x_org) - $urandom_range(0, 1000);
                default: x = 32'(x_org) + $urandom_range(0, 1 << 20);
            endcase
            add_beat(eval_beat(x));
        end
    endtask

    initial begin
        int n;
        x_org = 0;
        inv_step = 65536;
        n_loaded = 0;
        seg_valid = 0;
        for (int i = 0; i < 3; i++) win[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        add_beat(eval_beat(32'sd0));
        add_beat(load_beat(32'sd5, 1'b1));
        add_beat(load_beat(32'sd1, 1'b0));
        add_beat(load_beat(32'sd2, 1'b1));
        add_beat(load_beat(32'h7fffffff, 1'b0));
        add_beat(load_beat(32'h80000000, 1'b0));
        add_beat(load_beat(32'h7fffffff, 1'b1));
        add_beat(eval_beat(32'h80000000));
        add_beat(eval_beat(32'h7fffffff));
        add_beat(eval_beat(32'sd98304));
        add_beat(eval_beat(32'sd65536));
        add_beat(load_beat(32'sd0, 1'b0));
        add_beat(eval_beat(32'sd1000));
        add_beat(load_beat(32'sd65536, 1'b0));
        add_beat(load_beat(-32'sd65536, 1'b0));
        add_beat(load_beat(32'sd0, 1'b1));
        add_beat(eval_beat(32'sd32768));
        add_beat(eval_beat(32'sd150000));
        drain();
        write_reg(CFG_INVERSE_STEP, 32'd0);
        write_reg(CFG_X_ORIGIN, 32'h80000000);
        queue_queries(6);
        drain();
        // overflow load
        write_reg(CFG_INVERSE_STEP, 32'hffffffff);
        write_reg(CFG_X_ORIGIN, 32'h7fffffff);
        queue_table(NSEG + 4, 0);
        queue_queries(4);
        drain();
        // full-size load
        write_reg(CFG_X_ORIGIN, 32'h0);
        write_reg(CFG_INVERSE_STEP, 32'd65536);
        queue_table(NSEG + 1, 2);
        queue_queries(40);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_X_ORIGIN, $urandom_range(0, 3) == 0 ? $urandom
                                    : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
            write_reg(CFG_INVERSE_STEP, $urandom_range(0, 7) == 0 ? $urandom
                                        : $urandom_range(1 << 14, 1 << 18));
            n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 24);
            queue_table(n, $urandom_range(0, 2));
            queue_queries(60);
            if ($urandom_range(0, 2) == 0) add_beat(load_beat($urandom, 1'b0));
            if (ph == 11) quiet = 1'b1;
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/mcs_pkg.sv
rtl/mcs_queue.sv
rtl/mcs_front.sv
rtl/mcs_back.sv
rtl/monotone_cubic_spline_interpolator_top.sv
rtl/mcs_checker.sv
tb/tb_monotone_cubic_spline_interpolator_top.sv
